// ===== rtl/core/jpb_pkg.sv =====
// ----------------------------------------------------------------------------
// jpb_pkg
// Shared types, codes and character helpers for the token payload decoder.
// ----------------------------------------------------------------------------
package jpb_pkg;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_SIGNATURE,
    PH_DRAIN
  } phase_t;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
  localparam logic [1:0] ERR_SEGMENT  = 2'd2;
  localparam logic [1:0] ERR_DANGLING = 2'd3;

  localparam logic [7:0] CHAR_DOT = 8'h2E;

  // Results one character can cause, and the output queue around them.
  localparam int MAX_RES    = 3;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       payload_end;
    logic [1:0] error_code;
  } result_t;

  // {valid, 6-bit value} for one base64url symbol
  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } symbol_t;

  function automatic symbol_t sym_decode(input logic [7:0] c);
    symbol_t s;
    s.valid = 1'b1;
    s.value = 6'd0;
    case (c) inside
      [8'h41:8'h5A]: s.value = 6'(c - 8'h41);
      [8'h61:8'h7A]: s.value = 6'(c - 8'h61 + 8'd26);
      [8'h30:8'h39]: s.value = 6'(c - 8'h30 + 8'd52);
      8'h2D:         s.value = 6'd62;
      8'h5F:         s.value = 6'd63;
      default:       s.valid = 1'b0;
    endcase
    return s;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c inside {8'h20, [8'h09:8'h0D]});
  endfunction

endpackage

// ===== rtl/core/jwt_payload_base64url_decoder.sv =====
// A result passes through the input register and the result queue before it is taken.
// Throughput: one character per cycle while the queue has room; each character
//   yields 0 to 3 results, drained one per cycle (while res_ready is high) from
//   an 8-entry result queue. Input stalls only when under 3 entries are free.
// Reset (rst, synchronous): empties the queue and input stage, returns the
//   decoder to the header segment with no symbols gathered.
// ----------------------------------------------------------------------------
// jwt_payload_base64url_decoder
// Streaming decoder for the payload segment of a dot-separated token.
// ----------------------------------------------------------------------------
module jwt_payload_base64url_decoder (
  input  logic       clk,
  input  logic       rst,
  // character channel
  input  logic       char_valid,
  output logic       char_ready,
  input  logic [7:0] character,
  input  logic       final_char,
  // result channel
  output logic       res_valid,
  input  logic       res_ready,
  output logic [7:0] data_byte,
  output logic       has_data,
  output logic       payload_end,
  output logic [1:0] error_code
);
  import jpb_pkg::*;

  // Input register: holds one accepted item until the queue has room.
  logic       held;
  logic [7:0] char_q;
  logic       final_q;

  logic            room;
  logic            step;
  logic [1:0]      res_count;
  result_t [2:0]   results;
  result_t         head;

  // An item is processed whenever one is held and the worst case fits.
  assign step       = held && room;
  // A new item may enter while the held one leaves this cycle.
  assign char_ready = !held || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (char_valid && char_ready) begin
      held <= 1'b1;
    end else if (step) begin
      held <= 1'b0;
    end
  end

  // payload only; no reset needed
  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      char_q  <= character;
      final_q <= final_char;
    end
  end

  // Segment phase, group gathering and result generation.
  jpb_dec u_dec (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .character  (char_q),
    .final_char (final_q),
    .res_count  (res_count),
    .results    (results)
  );

  // Results of one item enter the queue together, in order.
  jpb_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_count (res_count),
    .wr_data  (results),
    .room     (room),
    .rd_valid (res_valid),
    .rd_ready (res_ready),
    .rd_data  (head)
  );

  assign data_byte   = head.data_byte;
  assign has_data    = head.has_data;
  assign payload_end = head.payload_end;
  assign error_code  = head.error_code;

endmodule

// ===== rtl/core/jpb_dec.sv =====
// ----------------------------------------------------------------------------
// jpb_dec
// Segment tracking and base64url group assembly; up to three results a step.
// ----------------------------------------------------------------------------
module jpb_dec (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [7:0]                  character,
  input  logic                        final_char,
  output logic [1:0]                  res_count,
  output jpb_pkg::result_t [2:0]      results
);
  import jpb_pkg::*;

  phase_t     phase, phase_next;
  logic [5:0] group_values [3];
  logic [5:0] group_values_next [3];
  logic [1:0] group_count, group_count_next;
  logic       payload_seen, payload_seen_next;

  symbol_t    sym;
  logic [7:0] b0, b1, b2;

  assign sym = sym_decode(character);
  assign b0  = {group_values[0], group_values[1][5:4]};
  assign b1  = {group_values[1][3:0], group_values[2][5:2]};
  assign b2  = {group_values[2][1:0], sym.value};

  always_comb begin
    phase_next        = phase;
    group_values_next = group_values;
    group_count_next  = group_count;
    payload_seen_next = payload_seen;
    res_count         = 2'd0;
    results           = '0;

    case (phase)
      PH_HEADER: begin
        if (final_char) begin
          results[0].error_code = ERR_SEGMENT;
          res_count = 2'd1;
        end else if (character == CHAR_DOT) begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (character == CHAR_DOT) begin
          res_count = 2'd1;
          if (!payload_seen) begin
            results[0].error_code = ERR_SEGMENT;
            phase_next = PH_DRAIN;
          end else if (group_count == 2'd1) begin
            results[0].error_code = ERR_DANGLING;
            phase_next = PH_DRAIN;
          end else begin
            phase_next = PH_SIGNATURE;
            case (group_count)
              2'd2: results[0] = '{b0, 1'b1, 1'b1, ERR_NONE};
              2'd3: begin
                results[0] = '{b0, 1'b1, 1'b0, ERR_NONE};
                results[1] = '{b1, 1'b1, 1'b1, ERR_NONE};
                res_count  = 2'd2;
              end
              default: results[0] = '{8'd0, 1'b0, 1'b1, ERR_NONE};
            endcase
          end
        end else begin
          payload_seen_next = 1'b1;
          if (is_blank(character)) begin
            if (final_char) begin
              results[0].error_code = ERR_SEGMENT;
              res_count = 2'd1;
            end
          end else if (!sym.valid) begin
            results[0].error_code = ERR_BAD_CHAR;
            res_count  = 2'd1;
            phase_next = PH_DRAIN;
          end else if (final_char) begin
            results[0].error_code = ERR_SEGMENT;
            res_count = 2'd1;
          end else if (group_count != 2'd3) begin
            group_values_next[group_count] = sym.value;
            group_count_next = group_count + 2'd1;
          end else begin
            // fourth symbol completes the group
            results[0] = '{b0, 1'b1, 1'b0, ERR_NONE};
            results[1] = '{b1, 1'b1, 1'b0, ERR_NONE};
            results[2] = '{b2, 1'b1, 1'b0, ERR_NONE};
            res_count  = 2'd3;
            group_values_next = '{default: 6'd0};
            group_count_next  = 2'd0;
          end
        end
      end
      default: ;
    endcase

    if (final_char) begin
      phase_next        = PH_HEADER;
      group_values_next = '{default: 6'd0};
      group_count_next  = 2'd0;
      payload_seen_next = 1'b0;
    end

    if (!step) begin
      res_count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      group_values <= '{default: 6'd0};
      group_count  <= 2'd0;
      payload_seen <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      group_values <= group_values_next;
      group_count  <= group_count_next;
      payload_seen <= payload_seen_next;
    end
  end

endmodule

// ===== rtl/core/jpb_fifo.sv =====
// ----------------------------------------------------------------------------
// jpb_fifo
// Result queue: up to three results in a cycle, one out a cycle when read.
// ----------------------------------------------------------------------------
module jpb_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [1:0]                  wr_count,
  input  jpb_pkg::result_t [2:0]      wr_data,
  output logic                        room,
  output logic                        rd_valid,
  input  logic                        rd_ready,
  output jpb_pkg::result_t            rd_data
);
  import jpb_pkg::*;

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               pop;

  assign pop      = rd_valid && rd_ready;
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  // enough space for the worst-case step
  assign room     = (count <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_RES));

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < wr_count) begin
        mem[wr_ptr + FIFO_AW'(i)] <= wr_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(wr_count);
      rd_ptr <= rd_ptr + FIFO_AW'(pop);
      count  <= count + (FIFO_AW+1)'(wr_count) - (FIFO_AW+1)'(pop);
    end
  end

endmodule
